[src/pwli_pkg.sv]
package pwli_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int NUM_TABLES_DEF = 4;

  localparam int NUM_CFG_REGS = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 7;

  localparam int IN_TUSER_W  = 3;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 104;

  localparam int RES_W  = 48;
  localparam int SEG_W  = 6;
  localparam int STAT_W = 2;

  // bit-serial divider: numerator width and iteration counter
  localparam int DIV_BITS = 82;
  localparam int DCNT_W   = 7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FEW     = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_DV = 2'd2;
  localparam logic [STAT_W-1:0] ST_SAT     = 2'd3;

  localparam logic [RES_W-1:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [RES_W-1:0] LIM_NEG = 48'h8000_0000_0000;

  // returns {saturated, signed result}
  function automatic logic [RES_W:0] clamp48(input logic neg, input logic ovf,
                                             input logic [RES_W-1:0] q);
    logic             s;
    logic [RES_W-1:0] v;
    s = ovf || (neg ? (q > LIM_NEG) : (q > LIM_POS));
    v = s ? (neg ? LIM_NEG : LIM_POS) : q;
    return {s, neg ? (48'd0 - v) : v};
  endfunction

endpackage

[src/piecewise_linear_table_interp.sv]
// Load item: written to the table on intake, no result; loads can follow back to back
// while no result waits. Evaluate item: a search for the segment, then two bit-serial
// divisions of an 82-bit numerator, for current and slope.
// Zero-width segment: no divisions; fewer than two points: result straight from intake.
// One item in flight; ready again the cycle after the result is taken.
// Reset (rst_n, synchronous, active low) clears counts and handshake; tables undefined.
module piecewise_linear_table_interp #(
  parameter int MAX_POINTS = pwli_pkg::MAX_POINTS_DEF,
  parameter int NUM_TABLES = pwli_pkg::NUM_TABLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pwli_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwli_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tuser, low bit up: cmd(1), table_select(2)
  input  logic [pwli_pkg::IN_TUSER_W-1:0]  in_tuser,
  // tdata, low bit up: entry_index(6), entry_voltage(32), entry_current(32),
  // voltage(32), area(32), zero pad(2)
  input  logic [pwli_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, low bit up: current(48), slope(48), segment(6), status(2)
  output logic [pwli_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int DEPTH = NUM_TABLES * MAX_POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NCW0  = $clog2(MAX_POINTS + 1);
  localparam int NCW   = (NCW0 > pwli_pkg::CFG_DATA_W) ? NCW0 : pwli_pkg::CFG_DATA_W;
  localparam logic [NCW-1:0] MAXN = NCW'(MAX_POINTS);

  typedef enum logic [20:0] {
    S_IDLE     = 21'd1 << 0,
    S_RD_FIRST = 21'd1 << 1,
    S_CMP_FST  = 21'd1 << 2,
    S_CMP_LST  = 21'd1 << 3,
    S_SRCH     = 21'd1 << 4,
    S_SRCH_CMP = 21'd1 << 5,
    S_RD_LO    = 21'd1 << 6,
    S_RD_HI    = 21'd1 << 7,
    S_DIFF     = 21'd1 << 8,
    S_M1       = 21'd1 << 9,
    S_M2       = 21'd1 << 10,
    S_SUM      = 21'd1 << 11,
    S_M3       = 21'd1 << 12,
    S_M4       = 21'd1 << 13,
    S_M5       = 21'd1 << 14,
    S_DIV_I    = 21'd1 << 15,
    S_FIN_I    = 21'd1 << 16,
    S_M6       = 21'd1 << 17,
    S_DIV_S    = 21'd1 << 18,
    S_FIN_S    = 21'd1 << 19,
    S_ZW       = 21'd1 << 20
  } state_t;

  state_t state_r, state_nxt;

  // unpack
  logic               f_cmd;
  logic [1:0]         f_tsel;
  logic [5:0]         f_eidx;
  logic [31:0]        f_ev, f_ec, f_v, f_area;
  assign f_cmd  = in_tuser[0];
  assign f_tsel = in_tuser[2:1];
  assign f_eidx = in_tdata[5:0];
  assign f_ev   = in_tdata[37:6];
  assign f_ec   = in_tdata[69:38];
  assign f_v    = in_tdata[101:70];
  assign f_area = in_tdata[133:102];

  // point counts
  logic [pwli_pkg::CFG_DATA_W-1:0] cnt_r [pwli_pkg::NUM_CFG_REGS];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pwli_pkg::NUM_CFG_REGS; i++) cnt_r[i] <= '0;
    end else if (cfg_valid && cfg_index < pwli_pkg::CFG_IDX_W'(pwli_pkg::NUM_CFG_REGS)) begin
      cnt_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  logic in_acc;
  assign in_tready = (state_r == S_IDLE) && !out_tvalid;
  assign in_acc    = in_tvalid && in_tready;

  // count for the addressed table, saturated to MAX_POINTS
  logic [NCW-1:0] n_sel;
  always_comb begin
    n_sel = NCW'(cnt_r[f_tsel]);
    if (32'(f_tsel) >= NUM_TABLES) n_sel = '0;
    else if (n_sel > MAXN) n_sel = MAXN;
  end

  // breakpoint store, one read port
  logic signed [31:0] mem_v [DEPTH];
  logic signed [31:0] mem_j [DEPTH];
  logic signed [31:0] rdv_r, rdj_r;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;

  assign wr_addr = AW'(32'(f_tsel) * MAX_POINTS + 32'(f_eidx));
  assign wr_en   = in_acc && (f_cmd == pwli_pkg::CMD_LOAD) && (32'(f_tsel) < NUM_TABLES)
                   && (32'(f_eidx) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_v[wr_addr] <= f_ev;
      mem_j[wr_addr] <= f_ec;
    end
    rdv_r <= mem_v[rd_addr];
    rdj_r <= mem_j[rd_addr];
  end

  // datapath registers
  logic [AW-1:0]      base_r;
  logic [NCW-1:0]     n_r, lo_r, hi_r;
  logic signed [31:0] vx_r, vl_r, jl_r;
  logic [31:0]        area_r;
  logic signed [32:0] dv_r, dj_r, x_r;
  logic signed [66:0] a_r, s_r;
  logic [65:0]        plo_r, mul_p_r;
  logic [pwli_pkg::DIV_BITS-1:0] num_r;
  logic [33:0]        rem_r;
  logic [pwli_pkg::RES_W-1:0] q_r, cur_r;
  logic               ovf_r, sat_r;
  logic [pwli_pkg::DCNT_W-1:0] dcnt_r;

  logic [NCW:0]   mid_sum;
  logic [NCW-1:0] mid;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[NCW:1];

  always_comb begin
    unique case (state_r)
      S_RD_FIRST: rd_addr = base_r;
      S_CMP_FST:  rd_addr = base_r + AW'(n_r - NCW'(1));
      S_SRCH:     rd_addr = base_r + AW'(mid);
      S_RD_LO:    rd_addr = base_r + AW'(lo_r);
      S_RD_HI:    rd_addr = base_r + AW'(hi_r);
      default:    rd_addr = base_r;
    endcase
  end

  // magnitudes
  logic [32:0] dv_mag, dj_mag, x_mag, jl_mag;
  logic [66:0] s_neg_v;
  logic [65:0] s_mag;
  assign dv_mag  = dv_r[32] ? 33'(-dv_r) : 33'(dv_r);
  assign dj_mag  = dj_r[32] ? 33'(-dj_r) : 33'(dj_r);
  assign x_mag   = x_r[32]  ? 33'(-x_r)  : 33'(x_r);
  assign jl_mag  = jl_r[31] ? 33'(-34'(jl_r)) : 33'(jl_r);
  assign s_neg_v = -s_r;
  assign s_mag   = s_r[66] ? s_neg_v[65:0] : s_r[65:0];

  // shared multiplier
  logic [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_M1: begin
        mul_a = jl_mag;
        mul_b = (dv_r == 33'sd0) ? {1'b0, area_r} : dv_mag;
      end
      S_M2: begin
        mul_a = x_mag;
        mul_b = dj_mag;
      end
      S_M3: begin
        mul_a = s_mag[32:0];
        mul_b = {1'b0, area_r};
      end
      S_M4: begin
        mul_a = s_mag[65:33];
        mul_b = {1'b0, area_r};
      end
      S_FIN_I: begin
        mul_a = {1'b0, area_r};
        mul_b = dj_mag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) mul_p_r <= mul_a * mul_b;

  // shared divider step (restoring, one bit a cycle)
  logic [33:0] rem_sh, rem_step;
  logic        q_bit;
  assign rem_sh   = {rem_r[32:0], num_r[pwli_pkg::DIV_BITS-1]};
  assign q_bit    = rem_sh >= {1'b0, dv_mag};
  assign rem_step = q_bit ? (rem_sh - {1'b0, dv_mag}) : rem_sh;

  // signed product terms and results
  logic [66:0] p_ext;
  logic [98:0] full_prod;
  logic [47:0] zw_mag;
  logic [pwli_pkg::RES_W:0] clamp_v;
  logic        cur_neg, slp_neg;
  assign p_ext     = {1'b0, mul_p_r};
  assign full_prod = {mul_p_r, 33'd0} + 99'(plo_r);
  assign zw_mag    = mul_p_r[63:16];
  assign cur_neg   = s_r[66] ^ dv_r[32];
  assign slp_neg   = dj_r[32] ^ dv_r[32];
  assign clamp_v   = pwli_pkg::clamp48((state_r == S_FIN_I) ? cur_neg : slp_neg, ovf_r, q_r);

  logic div_last;
  assign div_last = (dcnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_acc && f_cmd == pwli_pkg::CMD_EVAL && n_sel >= NCW'(2))
                    state_nxt = S_RD_FIRST;
      S_RD_FIRST: state_nxt = S_CMP_FST;
      S_CMP_FST:  state_nxt = (vx_r < rdv_r) ? S_RD_LO : S_CMP_LST;
      S_CMP_LST:  state_nxt = S_SRCH;
      S_SRCH:     state_nxt = ((hi_r - lo_r) > NCW'(1)) ? S_SRCH_CMP : S_RD_LO;
      S_SRCH_CMP: state_nxt = S_SRCH;
      S_RD_LO:    state_nxt = S_RD_HI;
      S_RD_HI:    state_nxt = S_DIFF;
      S_DIFF:     state_nxt = S_M1;
      S_M1:       state_nxt = (dv_r == 33'sd0) ? S_ZW : S_M2;
      S_M2:       state_nxt = S_SUM;
      S_SUM:      state_nxt = S_M3;
      S_M3:       state_nxt = S_M4;
      S_M4:       state_nxt = S_M5;
      S_M5:       state_nxt = S_DIV_I;
      S_DIV_I:    if (div_last) state_nxt = S_FIN_I;
      S_FIN_I:    state_nxt = S_M6;
      S_M6:       state_nxt = S_DIV_S;
      S_DIV_S:    if (div_last) state_nxt = S_FIN_S;
      S_FIN_S:    state_nxt = S_IDLE;
      S_ZW:       state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  logic        out_tvalid_r;
  logic [pwli_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      if ((state_r == S_IDLE && in_acc && f_cmd == pwli_pkg::CMD_EVAL && n_sel < NCW'(2))
          || state_r == S_ZW || state_r == S_FIN_S)
        out_tvalid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        base_r <= AW'(32'(f_tsel) * MAX_POINTS);
        n_r    <= n_sel;
        vx_r   <= f_v;
        area_r <= f_area;
        // a waiting result must hold, so only touch the output on intake
        if (in_acc) out_tdata_r <= {pwli_pkg::ST_FEW, 6'd0, 48'd0, 48'd0};
      end
      S_CMP_FST: begin
        lo_r <= '0;
        hi_r <= NCW'(1);
      end
      S_CMP_LST: begin
        if (vx_r > rdv_r) begin
          lo_r <= n_r - NCW'(2);
          hi_r <= n_r - NCW'(1);
        end else begin
          lo_r <= '0;
          hi_r <= n_r - NCW'(1);
        end
      end
      S_SRCH_CMP: begin
        if (vx_r < rdv_r) hi_r <= mid;
        else lo_r <= mid;
      end
      S_RD_HI: begin
        vl_r <= rdv_r;
        jl_r <= rdj_r;
      end
      S_DIFF: begin
        dv_r <= 33'(rdv_r) - 33'(vl_r);
        dj_r <= 33'(rdj_r) - 33'(jl_r);
        x_r  <= 33'(vx_r) - 33'(vl_r);
      end
      S_M2: a_r <= (jl_r[31] ^ dv_r[32]) ? -p_ext : p_ext;
      S_SUM: s_r <= a_r + ((x_r[32] ^ dj_r[32]) ? -p_ext : p_ext);
      S_M4: plo_r <= mul_p_r;
      S_M5: begin
        num_r  <= full_prod[97:16];
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        dcnt_r <= pwli_pkg::DCNT_W'(pwli_pkg::DIV_BITS - 1);
      end
      S_DIV_I, S_DIV_S: begin
        num_r  <= {num_r[pwli_pkg::DIV_BITS-2:0], 1'b0};
        rem_r  <= rem_step;
        q_r    <= {q_r[pwli_pkg::RES_W-2:0], q_bit};
        ovf_r  <= ovf_r | q_r[pwli_pkg::RES_W-1];
        dcnt_r <= dcnt_r - pwli_pkg::DCNT_W'(1);
      end
      S_FIN_I: begin
        cur_r <= clamp_v[pwli_pkg::RES_W-1:0];
        sat_r <= clamp_v[pwli_pkg::RES_W];
      end
      S_M6: begin
        num_r  <= pwli_pkg::DIV_BITS'({mul_p_r, 8'd0});
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        dcnt_r <= pwli_pkg::DCNT_W'(pwli_pkg::DIV_BITS - 1);
      end
      S_FIN_S: begin
        out_tdata_r <= {(sat_r || clamp_v[pwli_pkg::RES_W]) ? pwli_pkg::ST_SAT : pwli_pkg::ST_OK,
                        pwli_pkg::SEG_W'(lo_r), clamp_v[pwli_pkg::RES_W-1:0], cur_r};
      end
      S_ZW: begin
        out_tdata_r <= {pwli_pkg::ST_ZERO_DV, pwli_pkg::SEG_W'(lo_r), 48'd0,
                        jl_r[31] ? (48'd0 - zw_mag) : zw_mag};
      end
      default: ;
    endcase
  end

endmodule

[src/pwli_checker.sv]
module pwli_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [pwli_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pwli_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // one item in flight: no intake while a result waits
  a_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("intake while result pending");

  // a load never yields a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == pwli_pkg::CMD_LOAD) |=> !out_tvalid)
    else $error("result after load");

  // too few points gives zeroed fields
  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[103:102] == pwli_pkg::ST_FEW) |-> (out_tdata[101:0] == '0))
    else $error("nonzero fields with too few points");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind piecewise_linear_table_interp pwli_props u_pwli_props (.*);
